/* sv/assert_macros.svh */
// Assertion macros for the RTL of the event track.
// No dependencies; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// General property, checked on every rising edge outside reset
`define TET_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold outside reset
`define TET_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TET_ASSERT(lbl, clk, rst_n, prop, msg)
`define TET_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* sv/tet_pkg.sv */
// Shared constants, command and status codes and the result type of the event track.
// No dependencies.
package tet_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF        = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed field widths
  localparam int TICK_W    = 31;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int IN_PAY_W  = 32;
  localparam int OUT_PAY_W = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GATHER = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One result beat
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 has_entry;
    logic [TICK_W-1:0]    entry_start;
    logic [TICK_W-1:0]    entry_end;
    logic [OUT_PAY_W-1:0] entry_payload;
    logic                 last;
  } tet_res_t;

endpackage

/* sv/tet_if.sv */
// Valid/ready channel interfaces for the command input and the result output.
// Depends on tet_pkg for the field widths.
interface tet_in_if;
  logic                          valid;
  logic                          ready;
  logic [tet_pkg::CMD_W-1:0]     cmd;
  logic [tet_pkg::TICK_W-1:0]    first_tick;
  logic [tet_pkg::TICK_W-1:0]    second_tick;
  logic [tet_pkg::IN_PAY_W-1:0]  op_payload;

  modport source (output valid, cmd, first_tick, second_tick, op_payload, input ready);
  modport sink   (input valid, cmd, first_tick, second_tick, op_payload, output ready);
endinterface

interface tet_out_if;
  logic                          valid;
  logic                          ready;
  logic [tet_pkg::STATUS_W-1:0]  status;
  logic                          has_entry;
  logic [tet_pkg::TICK_W-1:0]    entry_start;
  logic [tet_pkg::TICK_W-1:0]    entry_end;
  logic [tet_pkg::OUT_PAY_W-1:0] entry_payload;
  logic                          last;

  modport source (output valid, status, has_entry, entry_start, entry_end, entry_payload,
                  last, input ready);
  modport sink   (input valid, status, has_entry, entry_start, entry_end, entry_payload,
                  last, output ready);
endinterface

/* sv/tet_mem.sv */
// Entry store of the event track: one write port, one registered read port.
// No package dependencies; entry layout is set by the instantiating module.
module tet_mem #(
  parameter int DEPTH = 32,
  parameter int EW    = 94
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [EW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [EW-1:0]            rdata_o
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tet_out.sv */
// Result output register of the event track: holds one beat until the sink takes it.
// Depends on tet_pkg (result type) and tet_out_if.
module tet_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tet_pkg::tet_res_t res_i,
  output logic              free_o,
  tet_out_if.source         out_o
);

  logic              vld_q;
  tet_pkg::tet_res_t res_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (out_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = vld_q;
  assign out_o.status        = res_q.status;
  assign out_o.has_entry     = res_q.has_entry;
  assign out_o.entry_start   = res_q.entry_start;
  assign out_o.entry_end     = res_q.entry_end;
  assign out_o.entry_payload = res_q.entry_payload;
  assign out_o.last          = res_q.last;

endmodule

/* sv/timed_event_track.sv */
// Timed event track: ordered ring in a synchronous store with one write and one read port;
// one item at a time. Each entry visited takes a read and then a compare. An add is dropped
// when the track is full and the new start is above every entry. A new item can be accepted
// in the cycle after the final beat is formed; output stalls delay this. A beat shows in the
// cycle after it is formed. Reset empties the track.
// Depends on tet_pkg, tet_if, tet_mem, tet_out and assert_macros.svh.
`include "assert_macros.svh"

module timed_event_track #(
  parameter int DEPTH        = tet_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = tet_pkg::PAYLOAD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tet_in_if.sink    in_i,
  tet_out_if.source out_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int PW = (PAYLOAD_BITS < tet_pkg::IN_PAY_W) ? PAYLOAD_BITS : tet_pkg::IN_PAY_W;
  localparam int TW = tet_pkg::TICK_W;
  localparam int EW = 2 * TW + PW;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef struct packed {
    logic [TW-1:0] start;
    logic [TW-1:0] stop;
    logic [PW-1:0] pay;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ARD, S_ACK, S_ADEC, S_WPREV, S_WNEW,
    S_GPRD, S_GPCK, S_GRD, S_GCK, S_RESP
  } state_e;

  // Ring position of entry i behind the head
  function automatic logic [IW-1:0] slot_of(logic [IW-1:0] head, logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(i);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[IW-1:0];
  endfunction

  state_e                        state_q, state_d;
  logic [TW-1:0]                 t1_q, t1_d, t2_q, t2_d;
  logic [PW-1:0]                 pay_q, pay_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [IW-1:0]                 head_q, head_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  ent_t                          prev_q, prev_d;
  ent_t                          pend_q, pend_d;
  logic                          pend_vld_q, pend_vld_d;
  logic [tet_pkg::STATUS_W-1:0]  status_q, status_d;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  ent_t          mem_wdata;
  logic [EW-1:0] mem_rdata;
  ent_t          rd;

  logic              out_load, out_free;
  tet_pkg::tet_res_t out_res;

  assign rd         = mem_rdata;
  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer: walks the ring one entry per read
  always_comb begin
    state_d    = state_q;
    t1_d       = t1_q;
    t2_d       = t2_q;
    pay_d      = pay_q;
    idx_d      = idx_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    prev_d     = prev_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    status_d   = status_q;
    mem_we     = 1'b0;
    mem_waddr  = head_q;
    mem_wdata  = '{start: t1_q, stop: t2_q, pay: pay_q};
    mem_re     = 1'b0;
    mem_raddr  = slot_of(head_q, idx_q);
    out_load   = 1'b0;
    out_res    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          t1_d     = in_i.first_tick;
          t2_d     = in_i.second_tick;
          pay_d    = in_i.op_payload[PW-1:0];
          idx_d    = '0;
          status_d = tet_pkg::ST_OK;
          if (in_i.cmd == tet_pkg::CMD_ADD) begin
            state_d = S_ARD;
          end else if (in_i.cmd == tet_pkg::CMD_GATHER) begin
            state_d = S_GPRD;
          end else begin
            if (in_i.cmd == tet_pkg::CMD_CLEAR) cnt_d = '0;
            state_d = S_RESP;
          end
        end
      end
      // Add: find the first entry whose start is not below the new start
      S_ARD: begin
        if (idx_q == cnt_q) begin
          state_d = S_ADEC;
        end else begin
          mem_re  = 1'b1;
          state_d = S_ACK;
        end
      end
      S_ACK: begin
        if (rd.start < t1_q) begin
          prev_d  = rd;
          idx_d   = idx_q + CW'(1);
          state_d = S_ARD;
        end else begin
          state_d = S_ADEC;
        end
      end
      S_ADEC: begin
        if (idx_q == cnt_q && cnt_q == DEPTH_C) begin
          status_d = tet_pkg::ST_FULL;
          state_d  = S_RESP;
        end else begin
          status_d = (idx_q != cnt_q) ? tet_pkg::ST_TRUNC : tet_pkg::ST_OK;
          state_d  = (idx_q != '0) ? S_WPREV : S_WNEW;
        end
      end
      // Close the last kept entry at the new start
      S_WPREV: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head_q, idx_q - CW'(1));
        mem_wdata = '{start: prev_q.start, stop: t1_q, pay: prev_q.pay};
        state_d   = S_WNEW;
      end
      S_WNEW: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head_q, idx_q);
        cnt_d     = idx_q + CW'(1);
        state_d   = S_RESP;
      end
      // Gather: pop expired front entries
      S_GPRD: begin
        if (cnt_q == '0) begin
          state_d = S_GRD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head_q;
          state_d   = S_GPCK;
        end
      end
      S_GPCK: begin
        if (t1_q > rd.stop) begin
          head_d  = slot_of(head_q, CW'(1));
          cnt_d   = cnt_q - CW'(1);
          state_d = S_GPRD;
        end else begin
          state_d = S_GRD;
        end
      end
      // Gather: emit leading entries, one held back to mark the last
      S_GRD: begin
        if (idx_q == cnt_q) begin
          state_d = S_RESP;
        end else begin
          mem_re  = 1'b1;
          state_d = S_GCK;
        end
      end
      S_GCK: begin
        if (rd.start < t2_q) begin
          if (!pend_vld_q) begin
            pend_d     = rd;
            pend_vld_d = 1'b1;
            idx_d      = idx_q + CW'(1);
            state_d    = S_GRD;
          end else if (out_free) begin
            out_load   = 1'b1;
            out_res    = '{status: tet_pkg::ST_OK, has_entry: 1'b1,
                           entry_start: pend_q.start, entry_end: pend_q.stop,
                           entry_payload: tet_pkg::OUT_PAY_W'(pend_q.pay), last: 1'b0};
            pend_d     = rd;
            idx_d      = idx_q + CW'(1);
            state_d    = S_GRD;
          end
        end else begin
          state_d = S_RESP;
        end
      end
      // Final beat of the item
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_vld_q) begin
            out_res = '{status: tet_pkg::ST_OK, has_entry: 1'b1,
                        entry_start: pend_q.start, entry_end: pend_q.stop,
                        entry_payload: tet_pkg::OUT_PAY_W'(pend_q.pay), last: 1'b1};
          end else begin
            out_res        = '0;
            out_res.status = status_q;
            out_res.last   = 1'b1;
          end
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      t1_q       <= '0;
      t2_q       <= '0;
      pay_q      <= '0;
      idx_q      <= '0;
      head_q     <= '0;
      cnt_q      <= '0;
      prev_q     <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      status_q   <= tet_pkg::ST_OK;
    end else begin
      state_q    <= state_d;
      t1_q       <= t1_d;
      t2_q       <= t2_d;
      pay_q      <= pay_d;
      idx_q      <= idx_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      prev_q     <= prev_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      status_q   <= status_d;
    end
  end

  tet_mem #(
    .DEPTH (DEPTH),
    .EW    (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tet_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .res_i  (out_res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  // Checks
  `TET_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > DEPTH_C, "entry count above depth")
  `TET_ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, out_load && out_o.valid && !out_o.ready, "result overwritten while stalled")
  `TET_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> (state_q != S_IDLE), "item accepted but sequencer idle")
  `TET_ASSERT(a_head_pops, clk_i, rst_ni, (!$stable(head_q)) |-> (cnt_q + CW'(1) == $past(cnt_q)), "head moved without a pop")
  `TET_ASSERT(a_pend_gather, clk_i, rst_ni, pend_vld_q |-> (state_q == S_GRD || state_q == S_GCK || state_q == S_RESP), "held entry outside gather")

endmodule
